FILE: hw/rtl/blt_pkg.sv
`timescale 1ns / 1ps

package blt_pkg;

   // default store sizes
   localparam int BYTE_DEPTH_DEF = 4096;
   localparam int LINE_DEPTH_DEF = 1024;

   // fixed field widths
   localparam int KIND_W   = 2;
   localparam int DATA_W   = 8;
   localparam int LINE_W   = 16;
   localparam int OFFSET_W = 12;
   localparam int STATUS_W = 2;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PATCH  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_DONE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic       load_req;
      logic       do_append;
      logic       do_patch;
      logic       search_init;
      logic       search_read;
      logic       search_step;
      logic       final_read;
      logic       out_load;
      logic       lookup_ok;
      status_type out_status;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              store_full;
      logic              table_full;
      logic              pos_oob;
      logic              table_empty;
      logic              search_done;
   } flag_type;

endpackage

FILE: hw/rtl/blt_req_if.sv
`timescale 1ns / 1ps

interface blt_req_if;
   logic                           valid;
   logic                           ready;
   logic [blt_pkg::KIND_W-1:0]     kind;
   logic [blt_pkg::DATA_W-1:0]     data_byte;
   logic [blt_pkg::LINE_W-1:0]     source_line;
   logic [blt_pkg::OFFSET_W-1:0]   offset;

   modport source (output valid, kind, data_byte, source_line, offset, input ready);
   modport sink (input valid, kind, data_byte, source_line, offset, output ready);
endinterface

FILE: hw/rtl/blt_rsp_if.sv
`timescale 1ns / 1ps

interface blt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [blt_pkg::LINE_W-1:0]     line_found;
   logic [blt_pkg::DATA_W-1:0]     byte_read;
   logic [blt_pkg::STATUS_W-1:0]   status;

   modport source (output valid, line_found, byte_read, status, input ready);
   modport sink (input valid, line_found, byte_read, status, output ready);
endinterface

FILE: hw/rtl/blt_datapath.sv
`timescale 1ns / 1ps

module blt_datapath #(
   parameter int BYTE_DEPTH = blt_pkg::BYTE_DEPTH_DEF,
   parameter int LINE_DEPTH = blt_pkg::LINE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [blt_pkg::KIND_W-1:0]     req_kind,
   input  logic [blt_pkg::DATA_W-1:0]     req_data_byte,
   input  logic [blt_pkg::LINE_W-1:0]     req_source_line,
   input  logic [blt_pkg::OFFSET_W-1:0]   req_offset,
   input  blt_pkg::cmd_type               cmd,
   output blt_pkg::flag_type              flags,
   output logic [blt_pkg::LINE_W-1:0]     rsp_line_found,
   output logic [blt_pkg::DATA_W-1:0]     rsp_byte_read,
   output logic [blt_pkg::STATUS_W-1:0]   rsp_status
);

   localparam int BW   = $clog2(BYTE_DEPTH);
   localparam int CW   = $clog2(BYTE_DEPTH + 1);
   localparam int IW   = $clog2(LINE_DEPTH);
   localparam int EW   = $clog2(LINE_DEPTH + 1);
   localparam int PW   = (CW > blt_pkg::OFFSET_W) ? CW : blt_pkg::OFFSET_W;
   localparam int ENTW = blt_pkg::LINE_W + BW;

   // stores
   logic [blt_pkg::DATA_W-1:0] byte_mem [BYTE_DEPTH];
   logic [ENTW-1:0]            entry_mem [LINE_DEPTH];

   // latched request
   logic [blt_pkg::KIND_W-1:0]   kind_ff;
   logic [blt_pkg::DATA_W-1:0]   data_ff;
   logic [blt_pkg::LINE_W-1:0]   line_ff;
   logic [blt_pkg::OFFSET_W-1:0] pos_ff;

   // counters and bookkeeping
   logic [CW-1:0]              byte_count_ff, byte_count_in;
   logic [EW-1:0]              entry_count_ff, entry_count_in;
   logic [blt_pkg::LINE_W-1:0] last_line_ff;

   // search registers
   logic [IW-1:0]   lo_ff, hi_ff, mid_ff;
   logic [IW:0]     mid_sum;
   logic [IW-1:0]   mid_next;
   logic [ENTW-1:0] entry_rd_ff;
   logic [blt_pkg::DATA_W-1:0] byte_rd_ff;

   logic [PW-1:0] pos_ext;
   logic [PW-1:0] count_ext;
   logic [PW-1:0] start_ext;
   logic          need_entry;
   logic [EW-1:0] last_idx;

   assign pos_ext   = PW'(pos_ff);
   assign count_ext = PW'(byte_count_ff);
   assign start_ext = PW'(entry_rd_ff[BW-1:0]);
   assign last_idx  = entry_count_ff - EW'(1);

   assign need_entry = (entry_count_ff == '0) || (last_line_ff != line_ff);
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff} + (IW+1)'(1);
   assign mid_next   = mid_sum[IW:1];

   // status toward the controller
   assign flags.kind        = kind_ff;
   assign flags.store_full  = (byte_count_ff == CW'(BYTE_DEPTH));
   assign flags.table_full  = need_entry && (entry_count_ff == EW'(LINE_DEPTH));
   assign flags.pos_oob     = (pos_ext >= count_ext);
   assign flags.table_empty = (entry_count_ff == '0);
   assign flags.search_done = (lo_ff == hi_ff);

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= req_kind;
         data_ff <= req_data_byte;
         line_ff <= req_source_line;
         pos_ff  <= req_offset;
      end
   end

   // counter next values
   always_comb begin
      byte_count_in  = byte_count_ff;
      entry_count_in = entry_count_ff;
      if (cmd.do_append) begin
         byte_count_in = byte_count_ff + CW'(1);
         if (need_entry) begin
            entry_count_in = entry_count_ff + EW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         entry_count_ff <= '0;
      end else begin
         byte_count_ff  <= byte_count_in;
         entry_count_ff <= entry_count_in;
      end
   end

   // line of the newest entry
   always_ff @(posedge clock) begin
      if (cmd.do_append && need_entry) begin
         last_line_ff <= line_ff;
      end
   end

   // byte store port
   always_ff @(posedge clock) begin
      if (cmd.do_append) begin
         byte_mem[byte_count_ff[BW-1:0]] <= data_ff;
      end else if (cmd.do_patch) begin
         byte_mem[pos_ext[BW-1:0]] <= data_ff;
      end
      if (cmd.search_init) begin
         byte_rd_ff <= byte_mem[pos_ext[BW-1:0]];
      end
   end

   // line entry port
   always_ff @(posedge clock) begin
      if (cmd.do_append && need_entry) begin
         entry_mem[entry_count_ff[IW-1:0]] <= {line_ff, byte_count_ff[BW-1:0]};
      end
      if (cmd.search_read) begin
         entry_rd_ff <= entry_mem[mid_next];
      end else if (cmd.final_read) begin
         entry_rd_ff <= entry_mem[lo_ff];
      end
   end

   // binary search bounds
   always_ff @(posedge clock) begin
      if (cmd.search_init) begin
         lo_ff <= '0;
         hi_ff <= last_idx[IW-1:0];
      end else if (cmd.search_read) begin
         mid_ff <= mid_next;
      end else if (cmd.search_step) begin
         if (start_ext <= pos_ext) begin
            lo_ff <= mid_ff;
         end else begin
            hi_ff <= mid_ff - IW'(1);
         end
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status <= cmd.out_status;
         if (cmd.lookup_ok) begin
            rsp_line_found <= entry_rd_ff[ENTW-1:BW];
            rsp_byte_read  <= byte_rd_ff;
         end else begin
            rsp_line_found <= '0;
            rsp_byte_read  <= '0;
         end
      end
   end

endmodule

FILE: hw/rtl/blt_controller.sv
`timescale 1ns / 1ps

module blt_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  blt_pkg::flag_type    flags,
   output blt_pkg::cmd_type     cmd
);

   blt_pkg::state_type  state_ff, state_in;
   blt_pkg::status_type status_ff, status_in;
   logic                lookup_ok_ff, lookup_ok_in;
   logic                rsp_valid_ff, rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;

   // state and result bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= blt_pkg::S_IDLE;
         status_ff    <= blt_pkg::STAT_OK;
         lookup_ok_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         lookup_ok_ff <= lookup_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      lookup_ok_in = lookup_ok_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.lookup_ok  = lookup_ok_ff;
      cmd.out_status = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         blt_pkg::S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = blt_pkg::S_DECODE;
            end
         end
         blt_pkg::S_DECODE: begin
            status_in    = blt_pkg::STAT_OK;
            lookup_ok_in = 1'b0;
            state_in     = blt_pkg::S_DONE;
            unique case (flags.kind)
               blt_pkg::KIND_APPEND: begin
                  if (flags.store_full || flags.table_full) begin
                     status_in = blt_pkg::STAT_FULL;
                  end else begin
                     cmd.do_append = 1'b1;
                  end
               end
               blt_pkg::KIND_PATCH: begin
                  if (flags.pos_oob) begin
                     status_in = blt_pkg::STAT_RANGE;
                  end else begin
                     cmd.do_patch = 1'b1;
                  end
               end
               blt_pkg::KIND_LOOKUP: begin
                  if (flags.pos_oob || flags.table_empty) begin
                     status_in = blt_pkg::STAT_RANGE;
                  end else begin
                     cmd.search_init = 1'b1;
                     lookup_ok_in    = 1'b1;
                     state_in        = blt_pkg::S_SRCH_RD;
                  end
               end
               default: begin
                  status_in = blt_pkg::STAT_OK;
               end
            endcase
         end
         blt_pkg::S_SRCH_RD: begin
            if (flags.search_done) begin
               cmd.final_read = 1'b1;
               state_in       = blt_pkg::S_DONE;
            end else begin
               cmd.search_read = 1'b1;
               state_in        = blt_pkg::S_SRCH_CMP;
            end
         end
         blt_pkg::S_SRCH_CMP: begin
            cmd.search_step = 1'b1;
            state_in        = blt_pkg::S_SRCH_RD;
         end
         blt_pkg::S_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = blt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = blt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/bytecode_line_table_unit.sv
`timescale 1ns / 1ps

// Byte store with a run-length source line table.
// req_ch carries one request per transfer: append a byte (tagged with its
// source line), patch a stored byte, or look up the line and byte at an offset.
// rsp_ch returns exactly one result per request, in request order, with
// line_found, byte_read and a status code (ok, full, out of range).
// One request is in flight at a time. For append, patch and unused kinds the
// request passes through the decode and done states, then rsp_ch valid rises,
// and the next request can transfer while that result is offered.
// A lookup adds binary search steps between decode and done, at most
// ceil(log2(entries)); each step is one read of the line entry memory
// followed by a compare.
// The result sits in an output register; a new request is taken as soon as
// the previous one has been moved there, even while rsp_ch is stalled.
// If the receiver stalls, a finished result waits until the register frees.
// Reset clears the byte and entry counts and the output valid; store
// contents are not cleared, and the counts keep every read inside written
// locations.
module bytecode_line_table_unit #(
   parameter int BYTE_DEPTH = blt_pkg::BYTE_DEPTH_DEF,
   parameter int LINE_DEPTH = blt_pkg::LINE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   blt_req_if.sink       req_ch,
   blt_rsp_if.source     rsp_ch
);

   blt_pkg::cmd_type  cmd;
   blt_pkg::flag_type flags;

   // sequencing
   blt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   // stores, counters and search
   blt_datapath #(
      .BYTE_DEPTH (BYTE_DEPTH),
      .LINE_DEPTH (LINE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_kind        (req_ch.kind),
      .req_data_byte   (req_ch.data_byte),
      .req_source_line (req_ch.source_line),
      .req_offset      (req_ch.offset),
      .cmd             (cmd),
      .flags           (flags),
      .rsp_line_found  (rsp_ch.line_found),
      .rsp_byte_read   (rsp_ch.byte_read),
      .rsp_status      (rsp_ch.status)
   );

`ifndef SYNTHESIS
   // one request at a time: no transfer right after one was taken
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while another is in flight");

   // a failed result (status not ok) carries zero payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status != blt_pkg::STAT_OK)) |->
         ((rsp_ch.line_found == '0) && (rsp_ch.byte_read == '0)))
      else $error("nonzero payload on a flagged result");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import blt_pkg::*;

   localparam int STORE_DEPTH = BYTE_DEPTH_DEF;
   localparam int ENTRY_DEPTH = LINE_DEPTH_DEF;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TAIL_CYCLES = 60;
   localparam int MAX_PRINTS = 40;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [DATA_W-1:0]   data_byte;
      logic [LINE_W-1:0]   source_line;
      logic [OFFSET_W-1:0] offset;
   } line_req_type;

   typedef struct {
      logic [LINE_W-1:0] line_found;
      logic [DATA_W-1:0] byte_read;
      status_type        status;
   } line_result_type;

   logic clock;
   logic reset;

   blt_req_if req_ch ();
   blt_rsp_if rsp_ch ();

   bytecode_line_table_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow copy of the byte store and the line table
   logic [DATA_W-1:0]   shadow_bytes [STORE_DEPTH];
   logic [LINE_W-1:0]   entry_line [ENTRY_DEPTH];
   logic [OFFSET_W:0]   entry_start [ENTRY_DEPTH];
   int                  byte_total;
   int                  entry_total;

   line_result_type pending_results [$];
   int           error_count;
   int           cycle_count;
   int           req_idle_pct;
   int           rsp_idle_pct;
   int           rsp_hold_cycles;
   logic [LINE_W-1:0] run_line;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // cycle count and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // next state of the line table and the result that one request gives
   function automatic line_result_type line_table_predict(line_req_type rq);
      line_result_type res;
      logic         need_entry;
      int           lo;
      int           hi;
      int           mid;
      res.line_found = '0;
      res.byte_read  = '0;
      res.status     = STAT_OK;
      case (rq.kind)
         KIND_APPEND: begin
            need_entry = (entry_total == 0) ||
                         (entry_line[entry_total-1] != rq.source_line);
            if (byte_total >= STORE_DEPTH) begin
               res.status = STAT_FULL;
            end else if (need_entry && entry_total >= ENTRY_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               if (need_entry) begin
                  entry_line[entry_total]  = rq.source_line;
                  entry_start[entry_total] = byte_total[OFFSET_W:0];
                  entry_total++;
               end
               shadow_bytes[byte_total] = rq.data_byte;
               byte_total++;
            end
         end
         KIND_PATCH: begin
            if (int'(rq.offset) >= byte_total) begin
               res.status = STAT_RANGE;
            end else begin
               shadow_bytes[rq.offset] = rq.data_byte;
            end
         end
         KIND_LOOKUP: begin
            if (int'(rq.offset) >= byte_total || entry_total == 0) begin
               res.status = STAT_RANGE;
            end else begin
               // last entry whose start is not above the offset
               lo = 0;
               hi = entry_total - 1;
               while (lo < hi) begin
                  mid = (lo + hi + 1) / 2;
                  if (int'(entry_start[mid]) <= int'(rq.offset)) lo = mid;
                  else hi = mid - 1;
               end
               res.line_found = entry_line[lo];
               res.byte_read  = shadow_bytes[rq.offset];
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (error_count < MAX_PRINTS)
         $display("mismatch @%0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   // one request transfer, with random idle cycles ahead of it
   task automatic send_item(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] data,
                            logic [LINE_W-1:0] line, logic [OFFSET_W-1:0] off);
      line_req_type rq;
      rq = '{kind: kind, data_byte: data, source_line: line, offset: off};
      if ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= kind;
      req_ch.data_byte   <= data;
      req_ch.source_line <= line;
      req_ch.offset      <= off;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_results.push_back(line_table_predict(rq));
   endtask

   // result side: compare each transfer, then pick ready for the next cycle
   initial begin
      line_result_type want;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result, status", int'(rsp_ch.status), 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_ch.line_found !== want.line_found)
                  report_mismatch("line_found", int'(rsp_ch.line_found),
                                  int'(want.line_found));
               if (rsp_ch.byte_read !== want.byte_read)
                  report_mismatch("byte_read", int'(rsp_ch.byte_read),
                                  int'(want.byte_read));
               if (rsp_ch.status !== want.status)
                  report_mismatch("status", int'(rsp_ch.status), int'(want.status));
            end
         end
         if (rsp_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic logic [OFFSET_W-1:0] pick_offset(bit in_range);
      if (in_range && byte_total > 0) return OFFSET_W'($urandom_range(byte_total - 1));
      return OFFSET_W'($urandom_range(STORE_DEPTH - 1));
   endfunction

   // empty table, line runs, line returning to an earlier value, range edges
   task automatic test_directed();
      send_item(KIND_LOOKUP, 8'h00, 16'h0000, 12'h000);
      send_item(KIND_PATCH, 8'hFF, 16'h0000, 12'h000);
      send_item(KIND_UNUSED, 8'hFF, 16'hFFFF, 12'hFFF);
      send_item(KIND_APPEND, 8'h00, 16'h0000, 12'h000);
      send_item(KIND_APPEND, 8'hFF, 16'h0000, 12'hFFF);
      send_item(KIND_APPEND, 8'hA5, 16'hFFFF, 12'h000);
      send_item(KIND_APPEND, 8'h5A, 16'hFFFF, 12'h000);
      send_item(KIND_APPEND, 8'h01, 16'h0000, 12'h000);
      for (int i = 0; i < 5; i++) send_item(KIND_LOOKUP, 8'h00, 16'h0000, i[11:0]);
      send_item(KIND_LOOKUP, 8'h00, 16'h0000, 12'h005);
      send_item(KIND_LOOKUP, 8'h00, 16'h0000, 12'hFFF);
      send_item(KIND_PATCH, 8'h00, 16'h0000, 12'h001);
      send_item(KIND_LOOKUP, 8'h00, 16'h0000, 12'h001);
      send_item(KIND_PATCH, 8'hFF, 16'h0000, 12'h004);
      send_item(KIND_LOOKUP, 8'h00, 16'h0000, 12'h004);
      send_item(KIND_PATCH, 8'h55, 16'h0000, 12'hFFF);
      send_item(KIND_UNUSED, 8'h00, 16'h0000, 12'h000);
   endtask

   // mostly line runs followed by lookups and patches in range, some noise
   task automatic test_random_mix(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 45) begin
            if ($urandom_range(99) < 25)
               run_line = $urandom_range(1) ? LINE_W'($urandom_range(65535)) :
                                              LINE_W'($urandom_range(7));
            send_item(KIND_APPEND, DATA_W'($urandom_range(255)), run_line,
                      pick_offset(0));
         end else if (r < 65) begin
            send_item(KIND_LOOKUP, DATA_W'($urandom_range(255)),
                      LINE_W'($urandom_range(65535)), pick_offset(1));
         end else if (r < 80) begin
            send_item(KIND_PATCH, DATA_W'($urandom_range(255)),
                      LINE_W'($urandom_range(65535)), pick_offset(1));
         end else if (r < 93) begin
            send_item($urandom_range(1) ? KIND_LOOKUP : KIND_PATCH,
                      DATA_W'($urandom_range(255)), LINE_W'($urandom_range(65535)),
                      pick_offset(0));
         end else begin
            send_item(KIND_UNUSED, DATA_W'($urandom_range(255)),
                      LINE_W'($urandom_range(65535)), pick_offset(0));
         end
      end
   endtask

   // receiver holds off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      rsp_hold_cycles = 300;
      test_random_mix(24);
   endtask

   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // reset, then the test sequence
   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.kind        = KIND_APPEND;
      req_ch.data_byte   = '0;
      req_ch.source_line = '0;
      req_ch.offset      = '0;
      byte_total         = 0;
      entry_total        = 0;
      error_count        = 0;
      cycle_count        = 0;
      rsp_hold_cycles    = 0;
      run_line           = '0;
      req_idle_pct       = 14;
      rsp_idle_pct       = 56;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_mix(170);

      req_idle_pct = 56;
      rsp_idle_pct = 14;
      test_random_mix(170);
      test_backpressure();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_mix(160);

      wait_drain();
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
